### rtl/core/dtbrc_pkg.sv
package dtbrc_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int POS_W      = $clog2(MAX_PIXELS);
  localparam int FRAME_W    = 17;
  localparam int DEPTH_W    = 32;
  localparam int WEIGHT_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = DEPTH_W + WEIGHT_W + 1;
  localparam int CFG_IDX_W  = 3;

  localparam logic [DEPTH_W-1:0]  DEPTH_INF  = '1;
  localparam logic [WEIGHT_W:0]   WEIGHT_ONE = (WEIGHT_W + 1)'(1 << WEIGHT_W);

  // register reset values
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT       = '0;
  localparam logic [DEPTH_W-1:0]  RST_MIN_RANGE    = DEPTH_W'(655);
  localparam logic [DEPTH_W-1:0]  RST_MAX_RANGE    = DEPTH_W'(65536);
  localparam logic [FRAME_W-1:0]  RST_FRAME_PIXELS = FRAME_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLUR_ENABLE  = 3'd0,
    REG_OLD_WEIGHT   = 3'd1,
    REG_CLIP_ENABLE  = 3'd2,
    REG_MIN_RANGE    = 3'd3,
    REG_MAX_RANGE    = 3'd4,
    REG_FRAME_PIXELS = 3'd5
  } cfg_reg_t;

  // per-pixel control that travels with the depth value
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last;
    logic             blend;
    logic             wr;
  } item_t;

  // writes still in flight, used by the read-after-write interlock
  typedef struct packed {
    logic             v1;
    logic             wr1;
    logic [POS_W-1:0] pos1;
    logic             v2;
    logic             wr2;
    logic [POS_W-1:0] pos2;
  } pend_t;

  typedef struct packed {
    logic               en;
    logic [POS_W-1:0]   addr;
    logic [DEPTH_W-1:0] data;
  } wr_t;

  // index of the last pixel of a frame; zero acts as one, large values clamp
  function automatic logic [POS_W-1:0] frame_last(input logic [FRAME_W-1:0] fp);
    logic [POS_W-1:0] r;
    if (fp == '0) begin
      r = '0;
    end else if (fp > FRAME_W'(MAX_PIXELS)) begin
      r = POS_W'(MAX_PIXELS - 1);
    end else begin
      r = POS_W'(fp - FRAME_W'(1));
    end
    return r;
  endfunction

endpackage

### rtl/core/depth_temporal_blur_range_clip_unit.sv
// an accepted input passes stage 1, stage 2, stage 3 and the output register
// throughput: one pixel per cycle unless the output stalls; for frames of one
//   or two pixels a pixel waits until the write-back of the same location lands
// history store is a single ram, read at accept and written back from stage 2
// reset: sync active-high; clears pipeline valids, history state and pixel count,
//   registers return to their defaults; the store itself is not cleared
module depth_temporal_blur_range_clip_unit import dtbrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // pixel input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DEPTH_W-1:0]   depth_in,
  // pixel output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DEPTH_W-1:0]   depth_out,
  output logic                 frame_end,
  // register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DEPTH_W-1:0]   cfg_data
);

  // configuration registers
  logic                blur_enable;
  logic [WEIGHT_W-1:0] old_frame_weight;
  logic                clip_enable;
  logic [DEPTH_W-1:0]  min_range;
  logic [DEPTH_W-1:0]  max_range;
  logic [FRAME_W-1:0]  frame_pixels;
  logic [POS_W-1:0]    last_index;   // clamped frame length minus one

  // frame tracking
  logic                hist_valid;   // store holds a full previous frame
  logic                filling;      // current frame is being stored as first frame
  logic [POS_W-1:0]    pixel_index;

  logic                cfg_wr;
  logic                frame_change;
  logic [POS_W-1:0]    idx;
  logic                last_pix;
  logic                fill_now;
  logic                hazard;
  logic                accept;
  logic                ld1;
  item_t               item;
  pend_t               pend;
  wr_t                 wr;
  logic [DEPTH_W-1:0]  rd_data;

  // registers take every write; the user must change config only while the pipe is idle (not enforced)
  assign cfg_ready    = 1'b1;
  assign cfg_wr       = cfg_valid && cfg_ready;
  assign frame_change = cfg_wr && (cfg_reg_t'(cfg_index) == REG_FRAME_PIXELS)
                        && (cfg_data[FRAME_W-1:0] != frame_pixels);

  always_ff @(posedge clk) begin
    if (rst) begin
      blur_enable      <= 1'b0;
      old_frame_weight <= RST_WEIGHT;
      clip_enable      <= 1'b1;
      min_range        <= RST_MIN_RANGE;
      max_range        <= RST_MAX_RANGE;
      frame_pixels     <= RST_FRAME_PIXELS;
      last_index       <= frame_last(RST_FRAME_PIXELS);
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLUR_ENABLE:  blur_enable      <= cfg_data[0];
        REG_OLD_WEIGHT:   old_frame_weight <= cfg_data[WEIGHT_W-1:0];
        REG_CLIP_ENABLE:  clip_enable      <= cfg_data[0];
        REG_MIN_RANGE:    min_range        <= cfg_data;
        REG_MAX_RANGE:    max_range        <= cfg_data;
        REG_FRAME_PIXELS: begin
          frame_pixels <= cfg_data[FRAME_W-1:0];
          last_index   <= frame_last(cfg_data[FRAME_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  // position of this pixel, wrapped if the frame ever shrank under it
  assign idx      = (pixel_index > last_index) ? '0 : pixel_index;
  assign last_pix = (idx == last_index);

  // a fill only starts at the top of a frame
  assign fill_now = blur_enable && !hist_valid && (filling || (idx == '0));

  assign item.pos   = idx;
  assign item.last  = last_pix;
  assign item.blend = blur_enable && hist_valid;
  assign item.wr    = (blur_enable && hist_valid) || fill_now;

  // hold a pixel whose location still has a write-back in flight
  assign hazard = (pend.v1 && pend.wr1 && (pend.pos1 == idx)) ||
                  (pend.v2 && pend.wr2 && (pend.pos2 == idx));

  assign in_stall = !ld1 || hazard;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid  <= 1'b0;
      filling     <= 1'b0;
      pixel_index <= '0;
    end else if (frame_change) begin
      hist_valid  <= 1'b0;
      filling     <= 1'b0;
      pixel_index <= '0;
    end else if (accept) begin
      if (!blur_enable) begin
        hist_valid <= 1'b0;
        filling    <= 1'b0;
      end else if (!hist_valid) begin
        filling <= fill_now && !last_pix;
        if (fill_now && last_pix) begin
          hist_valid <= 1'b1;
        end
      end
      pixel_index <= last_pix ? '0 : idx + POS_W'(1);
    end
  end

  // previous output frame, one word per pixel
  dtbrc_ram #(
    .WIDTH(DEPTH_W),
    .DEPTH(MAX_PIXELS)
  ) u_hist (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (accept),
    .raddr (idx),
    .rdata (rd_data)
  );

  // blend, write-back and clip pipeline
  dtbrc_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .acc       (accept),
    .item      (item),
    .scene     (depth_in),
    .rd_data   (rd_data),
    .weight    (old_frame_weight),
    .clip_en   (clip_enable),
    .min_range (min_range),
    .max_range (max_range),
    .out_stall (out_stall),
    .ld1       (ld1),
    .pend      (pend),
    .wr        (wr),
    .out_valid (out_valid),
    .depth_out (depth_out),
    .frame_end (frame_end)
  );

  // a completed history and an open fill exclude each other
  a_fill_xor_hist: assert property (@(posedge clk) disable iff (rst)
    !(hist_valid && filling))
    else $error("fill active with valid history");

  // pixel counter stays inside the frame
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    pixel_index <= last_index)
    else $error("pixel index beyond frame end");

endmodule

### rtl/core/dtbrc_ram.sv
module dtbrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/dtbrc_pipe.sv
module dtbrc_pipe import dtbrc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                acc,
  input  item_t               item,
  input  logic [DEPTH_W-1:0]  scene,
  input  logic [DEPTH_W-1:0]  rd_data,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic                clip_en,
  input  logic [DEPTH_W-1:0]  min_range,
  input  logic [DEPTH_W-1:0]  max_range,
  input  logic                out_stall,
  output logic                ld1,
  output pend_t               pend,
  output wr_t                 wr,
  output logic                out_valid,
  output logic [DEPTH_W-1:0]  depth_out,
  output logic                frame_end
);

  // stage 1: history word arrives, multiply
  logic               v1;
  item_t              ctl1;
  logic [DEPTH_W-1:0] sc1;
  // stage 2: sum and write back
  logic               v2;
  item_t              ctl2;
  logic [DEPTH_W-1:0] sc2;
  logic               bl2;
  logic [PROD_W-1:0]  pa2;
  logic [PROD_W-1:0]  pb2;
  // stage 3: range clip
  logic               v3;
  logic               last3;
  logic [DEPTH_W-1:0] val3;

  logic               ld2, ld3, ld_o;
  logic [WEIGHT_W:0]  wc;
  logic               bl1;
  logic [PROD_W-1:0]  pa1, pb1, sum2;
  logic [DEPTH_W-1:0] val2;
  logic               clip3;

  assign ld_o = !out_valid || !out_stall;
  assign ld3  = !v3 || ld_o;
  assign ld2  = !v2 || ld3;
  assign ld1  = !v1 || ld2;

  assign wc  = WEIGHT_ONE - {1'b0, weight};
  assign bl1 = ctl1.blend && (sc1 != DEPTH_INF) && (rd_data != DEPTH_INF);
  assign pa1 = PROD_W'(wc) * PROD_W'(sc1);
  assign pb1 = PROD_W'(weight) * PROD_W'(rd_data);

  assign sum2 = pa2 + pb2;
  assign val2 = bl2 ? sum2[FRAC_W+DEPTH_W-1:FRAC_W] : sc2;

  assign clip3 = clip_en && !((val3 > min_range) && (val3 < max_range));

  assign wr.en   = v2 && ctl2.wr && ld3;
  assign wr.addr = ctl2.pos;
  assign wr.data = val2;

  assign pend.v1   = v1;
  assign pend.wr1  = ctl1.wr;
  assign pend.pos1 = ctl1.pos;
  assign pend.v2   = v2;
  assign pend.wr2  = ctl2.wr;
  assign pend.pos2 = ctl2.pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= acc;
      end
      if (ld2) begin
        v2 <= v1;
      end
      if (ld3) begin
        v3 <= v2;
      end
      if (ld_o) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      ctl1 <= item;
      sc1  <= scene;
    end
    if (ld2) begin
      ctl2 <= ctl1;
      sc2  <= sc1;
      bl2  <= bl1;
      pa2  <= pa1;
      pb2  <= pb1;
    end
    if (ld3) begin
      val3  <= val2;
      last3 <= ctl2.last;
    end
    if (ld_o) begin
      depth_out <= clip3 ? DEPTH_INF : val3;
      frame_end <= last3;
    end
  end

  // two writes in flight never target the same location
  a_no_dup_pending: assert property (@(posedge clk) disable iff (rst)
    !(v1 && ctl1.wr && v2 && ctl2.wr && (ctl1.pos == ctl2.pos)))
    else $error("two pending writes to one history location");

  // a held stage keeps its value
  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !ld3 |=> v3 && $stable(val3))
    else $error("clip stage lost its value while held");

endmodule
